>>> rtl/core/srr_pkg.sv
// shared types and constants for the sequence reorder and reassembly receive core
// no dependencies; imported by srr_ctrl, srr_datapath and seq_reorder_reassembly_rx_core
`default_nettype none

package srr_pkg;

    localparam int SEQ_BITS   = 14;
    localparam int TAG_BITS   = 8;
    localparam int CHAN_BITS  = 16;
    localparam int OTAG_BITS  = 8;
    localparam int WINDOW     = 32;
    localparam int WIN_BITS   = $clog2(WINDOW);
    localparam int APB_DBITS  = 32;
    localparam int PADDR_BITS = 3;
    localparam int REG_IDX_BITS = PADDR_BITS - 2;

    localparam logic [SEQ_BITS-1:0] WINDOW_SEQ = SEQ_BITS'(WINDOW);

    localparam logic [REG_IDX_BITS-1:0] REG_REPLY_CHANNEL = REG_IDX_BITS'(0);

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_REL = 1'b1;

    typedef struct packed {
        logic [SEQ_BITS-1:0] seq_id;
        logic                first_frag;
        logic                last_frag;
        logic [7:0]          payload_tag;
    } srr_in_t;

    typedef struct packed {
        logic                 kind;
        logic [CHAN_BITS-1:0] ack_channel;
        logic [SEQ_BITS-1:0]  out_seq;
        logic                 out_first;
        logic                 out_last;
        logic [OTAG_BITS-1:0] out_tag;
        logic                 dropped;
        logic                 run_end;
    } srr_out_t;

    typedef struct packed {
        logic                last;
        logic                first;
        logic [TAG_BITS-1:0] tag;
    } srr_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_ACK,
        ST_RELEASE
    } srr_state_t;

    typedef struct packed {
        logic in_take;
        logic adv_step;
        logic ack_load;
        logic rel_load;
    } srr_cmd_t;

    typedef struct packed {
        logic need_adv;
        logic adv_hit;
        logic rel_pending;
        logic rel_last;
        logic out_free;
    } srr_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/seq_reorder_reassembly_rx_core.sv
// top level of the sequence reorder and reassembly receive core
// depends on srr_pkg, srr_ctrl, srr_datapath; holds the apb register file
//
// usage:
//   s_ channel: one datagram header per transaction (seq_id, flags, payload tag)
//   m_ channel: results; every datagram first gives an acknowledgement
//     (kind 0, dropped set when old, duplicate or outside the window), then,
//     when it completes a contiguous run ending in a last fragment, the
//     released datagrams in order (kind 1); run_end marks the last result
//     caused by one input transaction
//   apb port: register 0 at byte address 0 holds reply_channel
// timing:
//   the acknowledgement is loaded into the output register once it is free,
//   after the expected-id walk, which only a datagram at the expected id
//   makes (over the filled slots); released datagrams then leave one at a
//   time through the single output register; s_ready is high only between
//   transactions
// reset: window empty, expected and oldest ids zero, reply_channel zero;
//   no clearing pass, the core takes input in the first cycle after reset
// a stalled m_ready holds the output register; at most one more transaction is taken
`default_nettype none

module seq_reorder_reassembly_rx_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire srr_pkg::srr_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output srr_pkg::srr_out_t                     m_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [srr_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [srr_pkg::APB_DBITS-1:0]    pwdata,
    output logic [srr_pkg::APB_DBITS-1:0]         prdata,
    output logic                                  pready
);
    import srr_pkg::*;

    logic [CHAN_BITS-1:0]    reply_channel_reg, reply_channel_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    srr_cmd_t                cmd;
    srr_stat_t               stat;

    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign pready  = 1'b1;

    always_comb begin
        reply_channel_next = reply_channel_reg;
        if (psel && penable && pwrite && (reg_idx == REG_REPLY_CHANNEL)) begin
            reply_channel_next = pwdata[CHAN_BITS-1:0];
        end
        prdata = '0;
        if (reg_idx == REG_REPLY_CHANNEL) begin
            prdata = APB_DBITS'(reply_channel_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_channel_reg <= '0;
        end else begin
            reply_channel_reg <= reply_channel_next;
        end
    end

    srr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    srr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .reply_channel (reply_channel_reg),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/srr_ctrl.sv
// controller state machine: input take, expected-id walk, acknowledgement, release walk
// depends on srr_pkg; drives srr_datapath through srr_cmd_t
`default_nettype none

module srr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire srr_pkg::srr_stat_t stat,
    output srr_pkg::srr_cmd_t      cmd
);
    import srr_pkg::*;

    srr_state_t state_reg;
    srr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.in_take = 1'b1;
                    state_next  = stat.need_adv ? ST_ADVANCE : ST_ACK;
                end
            end
            ST_ADVANCE: begin
                if (stat.adv_hit) begin
                    cmd.adv_step = 1'b1;
                end else begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK: begin
                if (stat.out_free) begin
                    cmd.ack_load = 1'b1;
                    state_next   = stat.rel_pending ? ST_RELEASE : ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (stat.out_free) begin
                    cmd.rel_load = 1'b1;
                    if (stat.rel_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/srr_datapath.sv
// datapath: window pointers, slot valid and last bits, slot memory, output register
// depends on srr_pkg; commanded by srr_ctrl
`default_nettype none

module srr_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire srr_pkg::srr_in_t                s_data,
    input  wire logic [srr_pkg::CHAN_BITS-1:0]   reply_channel,
    input  wire srr_pkg::srr_cmd_t               cmd,
    output srr_pkg::srr_stat_t                   stat,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output srr_pkg::srr_out_t                    m_data
);
    import srr_pkg::*;

    logic [SEQ_BITS-1:0] expected_reg, expected_next;
    logic [SEQ_BITS-1:0] oldest_reg, oldest_next;
    logic [SEQ_BITS-1:0] rel_end_reg, rel_end_next;
    logic [WINDOW-1:0]   slot_valid_reg, slot_valid_next;
    logic [WINDOW-1:0]   slot_last_reg, slot_last_next;

    logic [SEQ_BITS-1:0] ack_seq_reg, ack_seq_next;
    logic                ack_first_reg, ack_first_next;
    logic                ack_last_reg, ack_last_next;
    logic                ack_drop_reg, ack_drop_next;

    srr_entry_t          slot_mem [WINDOW];
    srr_entry_t          rd_data_reg;

    logic                m_valid_reg, m_valid_next;
    srr_out_t            m_data_reg, m_data_next;

    logic [SEQ_BITS-1:0] in_off;
    logic [SEQ_BITS-1:0] in_ahead;
    logic [WIN_BITS-1:0] in_slot;
    logic                in_accept;
    logic [WIN_BITS-1:0] exp_slot;
    logic [WIN_BITS-1:0] old_slot;
    logic [SEQ_BITS-1:0] exp_dist;
    logic [SEQ_BITS-1:0] rel_dist;
    logic [SEQ_BITS-1:0] expected_inc;
    logic [SEQ_BITS-1:0] oldest_inc;
    logic                out_free;
    srr_entry_t          wr_entry;

    assign in_off       = s_data.seq_id - oldest_reg;
    assign in_ahead     = s_data.seq_id - expected_reg;
    assign in_slot      = s_data.seq_id[WIN_BITS-1:0];
    assign in_accept    = (in_off < WINDOW_SEQ) && (in_ahead < WINDOW_SEQ)
                          && !slot_valid_reg[in_slot];
    assign exp_slot     = expected_reg[WIN_BITS-1:0];
    assign old_slot     = oldest_reg[WIN_BITS-1:0];
    assign exp_dist     = expected_reg - oldest_reg;
    assign rel_dist     = rel_end_reg - oldest_reg;
    assign expected_inc = expected_reg + SEQ_BITS'(1);
    assign oldest_inc   = oldest_reg + SEQ_BITS'(1);
    assign out_free     = !m_valid_reg || m_ready;

    assign wr_entry.last  = s_data.last_frag;
    assign wr_entry.first = s_data.first_frag;
    assign wr_entry.tag   = s_data.payload_tag[TAG_BITS-1:0];

    assign stat.need_adv    = in_accept && (in_ahead == '0);
    assign stat.adv_hit     = (exp_dist < WINDOW_SEQ) && slot_valid_reg[exp_slot];
    assign stat.rel_pending = (rel_end_reg != oldest_reg);
    assign stat.rel_last    = (oldest_inc == rel_end_reg);
    assign stat.out_free    = out_free;

    always_comb begin
        expected_next   = expected_reg;
        oldest_next     = oldest_reg;
        rel_end_next    = rel_end_reg;
        slot_valid_next = slot_valid_reg;
        slot_last_next  = slot_last_reg;
        ack_seq_next    = ack_seq_reg;
        ack_first_next  = ack_first_reg;
        ack_last_next   = ack_last_reg;
        ack_drop_next   = ack_drop_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cmd.in_take) begin
            ack_seq_next   = s_data.seq_id;
            ack_first_next = s_data.first_frag;
            ack_last_next  = s_data.last_frag;
            ack_drop_next  = !in_accept;
            rel_end_next   = oldest_reg;
            if (in_accept) begin
                slot_valid_next[in_slot] = 1'b1;
                slot_last_next[in_slot]  = s_data.last_frag;
            end
        end

        if (cmd.adv_step) begin
            expected_next = expected_inc;
            if (slot_last_reg[exp_slot]) begin
                rel_end_next = expected_inc;
            end
        end

        if (cmd.ack_load) begin
            m_valid_next            = 1'b1;
            m_data_next.kind        = KIND_ACK;
            m_data_next.ack_channel = reply_channel;
            m_data_next.out_seq     = ack_seq_reg;
            m_data_next.out_first   = ack_first_reg;
            m_data_next.out_last    = ack_last_reg;
            m_data_next.out_tag     = '0;
            m_data_next.dropped     = ack_drop_reg;
            m_data_next.run_end     = (rel_end_reg == oldest_reg);
        end

        if (cmd.rel_load) begin
            m_valid_next              = 1'b1;
            m_data_next.kind          = KIND_REL;
            m_data_next.ack_channel   = '0;
            m_data_next.out_seq       = oldest_reg;
            m_data_next.out_first     = rd_data_reg.first;
            m_data_next.out_last      = rd_data_reg.last;
            m_data_next.out_tag       = OTAG_BITS'(rd_data_reg.tag);
            m_data_next.dropped       = 1'b0;
            m_data_next.run_end       = (oldest_inc == rel_end_reg);
            slot_valid_next[old_slot] = 1'b0;
            oldest_next               = oldest_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg   <= '0;
            oldest_reg     <= '0;
            rel_end_reg    <= '0;
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            expected_reg   <= expected_next;
            oldest_reg     <= oldest_next;
            rel_end_reg    <= rel_end_next;
            slot_valid_reg <= slot_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_last_reg <= slot_last_next;
        ack_seq_reg   <= ack_seq_next;
        ack_first_reg <= ack_first_next;
        ack_last_reg  <= ack_last_next;
        ack_drop_reg  <= ack_drop_next;
        m_data_reg    <= m_data_next;
    end

    // slot memory, read address follows the oldest pending id
    always_ff @(posedge aclk) begin
        if (cmd.in_take && in_accept) begin
            slot_mem[in_slot] <= wr_entry;
        end
        rd_data_reg <= slot_mem[oldest_next[WIN_BITS-1:0]];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_exp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_dist <= WINDOW_SEQ)
        else $error("expected id ran past the window");

    a_rel_end_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        rel_dist <= exp_dist)
        else $error("release end beyond contiguous run");

    a_rel_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rel_load |-> slot_valid_reg[old_slot])
        else $error("release of an empty slot");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ack_load || cmd.rel_load) |-> out_free)
        else $error("output register overwritten");

    a_oldest_moves_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.rel_load |=> (oldest_reg == $past(oldest_reg)))
        else $error("oldest id moved without a release");

endmodule

`default_nettype wire
